// ----- rtl/core/lpst_pkg.sv -----
// Shared constants, types and state codes for the linear probe symbol table.
package lpst_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int KEY_W       = 32;
  localparam int FLAG_W      = 8;
  localparam int IDX_W       = 10;
  localparam int ST_W        = 2;
  localparam int HASH_W      = 15;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [HASH_W-1:0] HASH_MASK = 15'o77777;
  localparam logic [FLAG_W-1:0] MASK_RESET = 8'hFF;

  localparam bit HOME_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam int RED_STEPS = HOME_POW2 ? 1 : (HASH_W + 1 - SLOT_W);
  localparam int RED_CW    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic [HASH_W:0] DVS_INIT = (HASH_W + 1)'(TABLE_SLOTS << (RED_STEPS - 1));

  typedef enum logic [ST_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic              occ;
    logic [KEY_W-1:0]  key;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic hash_en;
    logic probe_en;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic done;
  } sts_t;

endpackage

// ----- rtl/core/lpst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lpst_ctrl.sv -----
// Sequencer for clearing, home slot reduction and probing.
module lpst_ctrl
  import lpst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = HOME_POW2 ? S_PROBE : S_HASH;
      end
      S_HASH: begin
        if (sts.hash_last) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (sts.done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    ctl          = '0;
    busy         = 1'b1;
    unique case (state_r)
      S_CLEAR: ctl.clear_en = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_HASH:  ctl.hash_en  = 1'b1;
      S_PROBE: ctl.probe_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/core/lpst_dpath.sv -----
// Slot store, home slot reduction, probe compare and result register.
module lpst_dpath
  import lpst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [FLAG_W-1:0] in_req_flags,
  input  logic [FLAG_W-1:0] flag_mask,
  output sts_t              sts,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_slot_index,
  output logic [ST_W-1:0]   out_status
);

  logic [KEY_W-1:0]  key_r;
  logic [FLAG_W-1:0] flags_r;
  logic [HASH_W-1:0] rem_r;
  logic [HASH_W:0]   dvs_r;
  logic [RED_CW-1:0] kcnt_r;
  logic [SLOT_W-1:0] issue_pos_r;
  logic [SLOT_W-1:0] chk_pos_r;
  logic              chk_vld_r;
  logic [CNT_W-1:0]  chk_cnt_r;
  logic [SLOT_W-1:0] clr_addr_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_slot_index_r;
  status_t           out_status_r;

  logic [HASH_W-1:0] key_low;
  logic [HASH_W:0]   rem_ext;
  logic [HASH_W-1:0] rem_step;
  logic [SLOT_W-1:0] issue_inc;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] rd_bits;
  entry_t            wr_entry;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic              hit_empty;
  logic              hit_match;
  logic              hit_full;

  assign key_low  = in_key[HASH_W-1:0] & HASH_MASK;
  assign rem_ext  = {1'b0, rem_r};
  assign rem_step = (rem_ext >= dvs_r) ? HASH_W'(rem_ext - dvs_r) : rem_r;
  assign issue_inc = (issue_pos_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : issue_pos_r + 1'b1;

  assign rd_entry  = entry_t'(rd_bits);
  assign hit_empty = chk_vld_r && !rd_entry.occ;
  assign hit_match = chk_vld_r && rd_entry.occ && (rd_entry.key == key_r) &&
                     ((rd_entry.flags & flag_mask) == flags_r);
  assign hit_full  = chk_vld_r && !hit_empty && !hit_match &&
                     (chk_cnt_r == CNT_W'(TABLE_SLOTS - 1));

  assign sts.clear_last = (clr_addr_r == SLOT_W'(TABLE_SLOTS - 1));
  assign sts.hash_last  = (kcnt_r == '0);
  assign sts.done       = hit_empty || hit_match || hit_full;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = chk_pos_r;
    wr_entry = '0;
    if (ctl.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
    end else if (ctl.probe_en && hit_empty) begin
      wr_en          = 1'b1;
      wr_entry.occ   = 1'b1;
      wr_entry.key   = key_r;
      wr_entry.flags = flags_r;
    end
  end

  lpst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .raddr(issue_pos_r),
    .rdata(rd_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear_en) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (ctl.load) begin
        chk_vld_r <= 1'b0;
      end else if (ctl.probe_en) begin
        chk_vld_r <= !sts.done;
      end
      out_valid_r <= ctl.probe_en && sts.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r       <= in_key;
      flags_r     <= in_req_flags;
      rem_r       <= key_low;
      dvs_r       <= DVS_INIT;
      kcnt_r      <= RED_CW'(RED_STEPS - 1);
      issue_pos_r <= SLOT_W'(key_low);
      chk_cnt_r   <= '0;
    end
    if (ctl.hash_en) begin
      rem_r  <= rem_step;
      dvs_r  <= dvs_r >> 1;
      kcnt_r <= kcnt_r - 1'b1;
      if (sts.hash_last) begin
        issue_pos_r <= SLOT_W'(rem_step);
      end
    end
    if (ctl.probe_en) begin
      issue_pos_r <= issue_inc;
      chk_pos_r   <= issue_pos_r;
      if (chk_vld_r) begin
        chk_cnt_r <= chk_cnt_r + 1'b1;
      end
      if (sts.done) begin
        out_slot_index_r <= hit_full ? '0 : IDX_W'(chk_pos_r);
        if (hit_match) begin
          out_status_r <= ST_FOUND;
        end else if (hit_empty) begin
          out_status_r <= ST_INSERTED;
        end else begin
          out_status_r <= ST_FULL;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_index_r;
  assign out_status     = out_status_r;

endmodule

// ----- rtl/core/linear_probe_symbol_table.sv -----
// Top level of the linear probe symbol table with its configuration register.
//
//   channel  ports                                  handshake
//   input    in_key, in_req_flags                   start && !busy
//   result   out_slot_index, out_status             out_valid, one cycle
//   config   psel penable pwrite paddr pwdata ...   psel && penable && pwrite
//
// An accepted request probes slots from its home slot on. The result strobe
// is registered from the end of the probe; busy drops with the strobe, so the
// next request can be accepted at the edge that ends it. One slot is read per
// cycle from the slot RAM while probing. Table sizes that are not a power of
// two add 16 - ceil(log2) steps of the remainder unit before probing. After
// reset a clearing pass writes one slot per cycle, with busy high. The
// receiver cannot stall: each result is shown for exactly one cycle.
module linear_probe_symbol_table
  import lpst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [FLAG_W-1:0] in_req_flags,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_slot_index,
  output logic [ST_W-1:0]   out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  ctl_t              ctl;
  sts_t              sts;
  logic [FLAG_W-1:0] cfg_flag_match_mask_r;
  logic              cfg_wr;
  logic              cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ADDR_W-1] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? DATA_W'(cfg_flag_match_mask_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_flag_match_mask_r <= MASK_RESET;
    end else if (cfg_wr) begin
      cfg_flag_match_mask_r <= pwdata[FLAG_W-1:0];
    end
  end

  lpst_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  lpst_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_key        (in_key),
    .in_req_flags  (in_req_flags),
    .flag_mask     (cfg_flag_match_mask_r),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_slot_index(out_slot_index),
    .out_status    (out_status)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without work in flight");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_slot_index == '0)
    else $error("full result with nonzero slot index");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("clearing pass not running after reset");
`endif

endmodule

// ----- tb/sv/linear_probe_symbol_table_tb.sv -----
// Testbench for the linear probe symbol table: directed and random lookups against a scoreboard.
`timescale 1ns / 1ps

module linear_probe_symbol_table_tb;
  import lpst_pkg::*;

  localparam logic [ADDR_W-1:0] REG_FLAG_MASK = '0;
  localparam int WATCHDOG_LIMIT = 8 * TABLE_SLOTS + 2000;
  localparam int RANDOM_PER_MASK = 175;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    status_t          status;
  } slot_answer_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [FLAG_W-1:0] flags;
  } key_entry_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KEY_W-1:0]  in_key = '0;
  logic [FLAG_W-1:0] in_req_flags = '0;
  logic              out_valid;
  logic [IDX_W-1:0]  out_slot_index;
  logic [ST_W-1:0]   out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit                table_occ   [TABLE_SLOTS];
  logic [KEY_W-1:0]  table_key   [TABLE_SLOTS];
  logic [FLAG_W-1:0] table_flags [TABLE_SLOTS];
  logic [FLAG_W-1:0] match_mask = MASK_RESET;

  slot_answer_t pending_answers[$];
  key_entry_t   known_keys[$];
  int           fault_count = 0;
  int           cfg_fault_count = 0;
  int           idle_cycles = 0;
  bit           steady_run = 1'b0;

  linear_probe_symbol_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_key         (in_key),
    .in_req_flags   (in_req_flags),
    .out_valid      (out_valid),
    .out_slot_index (out_slot_index),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic slot_answer_t lookup_or_insert(input logic [KEY_W-1:0] key,
                                                    input logic [FLAG_W-1:0] flags);
    int unsigned  pos;
    slot_answer_t ans;
    pos = (key & HASH_MASK) % TABLE_SLOTS;
    ans.slot = '0;
    ans.status = ST_FULL;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!table_occ[pos]) begin
        table_occ[pos] = 1'b1;
        table_key[pos] = key;
        table_flags[pos] = flags;
        ans.slot = pos[IDX_W-1:0];
        ans.status = ST_INSERTED;
        return ans;
      end
      if (table_key[pos] == key && (table_flags[pos] & match_mask) == flags) begin
        ans.slot = pos[IDX_W-1:0];
        ans.status = ST_FOUND;
        return ans;
      end
      pos = (pos + 1) % TABLE_SLOTS;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      pending_answers.push_back(lookup_or_insert(in_key, in_req_flags));
    if (rst_n && psel && penable && pwrite && pready && paddr == REG_FLAG_MASK)
      match_mask = pwdata[FLAG_W-1:0];
  end

  always @(posedge clk) begin
    slot_answer_t due;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word slot=%0d status=%0d", $time, out_slot_index, out_status);
        fault_count++;
      end else begin
        due = pending_answers.pop_front();
        if (out_slot_index !== due.slot) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, due.slot, out_slot_index);
          fault_count++;
        end
        if (out_status !== due.status) begin
          $display("%0t: status expected %0d actual %0d", $time, due.status, out_status);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d words due", $time, pending_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_run)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_lookup(input logic [KEY_W-1:0] key, input logic [FLAG_W-1:0] flags);
    int gap;
    start <= 1'b1;
    in_key <= key;
    in_req_flags <= flags;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic read_mask(input logic [FLAG_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_FLAG_MASK;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FLAG_W-1:0] !== want) begin
      $display("%0t: flag_match_mask expected %0h actual %0h", $time, want,
               prdata[FLAG_W-1:0]);
      cfg_fault_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_match_mask(input logic [FLAG_W-1:0] value);
    drain_answers();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_FLAG_MASK;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    read_mask(value);
  endtask

  task automatic test_reset_mask();
    read_mask(MASK_RESET);
  endtask

  task automatic test_basic_probing();
    send_lookup(32'h0000_0000, 8'h00);
    send_lookup(32'h0000_0000, 8'h00);
    send_lookup(32'hFFFF_FFFF, 8'hFF);
    send_lookup(32'hFFFF_FFFF, 8'hFF);
    send_lookup(32'h0000_0400, 8'h01);
    send_lookup(32'h0000_03FF, 8'h80);
    send_lookup(32'h0000_0000, 8'h01);
    send_lookup(32'h8000_0000, 8'hAA);
    send_lookup(32'hAAAA_AAAA, 8'h55);
    send_lookup(32'h5555_5555, 8'hAA);
    send_lookup(32'h0000_0400, 8'h01);
    drain_answers();
  endtask

  task automatic test_flag_mask();
    set_match_mask(8'h0F);
    send_lookup(32'h0000_1234, 8'hF3);
    send_lookup(32'h0000_1234, 8'hF3);
    send_lookup(32'h0000_1234, 8'h03);
    send_lookup(32'h0000_0000, 8'h00);
    set_match_mask(8'h00);
    send_lookup(32'h0000_1234, 8'h00);
    send_lookup(32'h0000_1234, 8'h01);
    set_match_mask(MASK_RESET);
  endtask

  task automatic remember_key(input logic [KEY_W-1:0] key, input logic [FLAG_W-1:0] flags);
    key_entry_t e;
    e.key = key;
    e.flags = flags;
    if (known_keys.size() < 256)
      known_keys.push_back(e);
    else
      known_keys[$urandom_range(0, 255)] = e;
  endtask

  task automatic test_random_lookups();
    logic [FLAG_W-1:0] masks[4];
    logic [KEY_W-1:0]  key;
    logic [FLAG_W-1:0] flags;
    key_entry_t        pick;
    int                r;
    masks[0] = 8'hFF;
    masks[1] = 8'h00;
    masks[2] = FLAG_W'($urandom_range(1, 254));
    masks[3] = 8'h0F;
    foreach (masks[m]) begin
      set_match_mask(masks[m]);
      for (int n = 0; n < RANDOM_PER_MASK; n++) begin
        if (n % 40 == 0)
          steady_run = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0)
          drain_answers();
        r = $urandom_range(0, 99);
        if (known_keys.size() != 0)
          pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (known_keys.size() != 0 && r < 45) begin
          key = pick.key;
          case ($urandom_range(0, 4))
            0: flags = FLAG_W'($urandom);
            1: flags = pick.flags & match_mask;
            default: flags = pick.flags;
          endcase
        end else if (known_keys.size() != 0 && r < 70) begin
          key = $urandom;
          key[SLOT_W-1:0] = pick.key[SLOT_W-1:0];
          flags = FLAG_W'($urandom);
        end else begin
          key = $urandom;
          flags = FLAG_W'($urandom);
        end
        remember_key(key, flags);
        send_lookup(key, flags);
      end
    end
    steady_run = 1'b0;
    set_match_mask(MASK_RESET);
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    key_entry_t       pick;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!table_occ[i]) begin
        key = $urandom;
        key[HASH_W-1:0] = HASH_W'(i);
        send_lookup(key, FLAG_W'($urandom));
      end
    end
    drain_answers();
    for (int n = 0; n < 8; n++) begin
      send_lookup($urandom, FLAG_W'($urandom));
      pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_lookup(pick.key, pick.flags);
    end
    set_match_mask(8'h00);
    send_lookup(32'h0000_1234, 8'h80);
    drain_answers();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_mask();
    test_basic_probing();
    test_flag_mask();
    test_random_lookups();
    test_full_table();
    repeat (16) @(posedge clk);
    if (fault_count == 0 && cfg_fault_count == 0 && pending_answers.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
